// File: src/co_sfr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// co_sfr_pkg: CO sensor frame receiver shared definitions
// Frame constants, reject codes, register indexes and the poll result type.
// ----------------------------------------------------------------------------
package co_sfr_pkg;

    localparam int FrameLen = 19;

    localparam logic [7:0] HDR_BYTE   = 8'hAA;
    localparam logic [7:0] LEN_BYTE   = 8'h13;
    localparam logic [7:0] END_BYTE   = 8'h55;
    localparam logic [7:0] ALARM_MASK = 8'h40;
    localparam logic [7:0] FAULT_MASK = 8'h20;

    localparam logic [3:0]  MAX_REPEATS   = 4'd10;
    localparam logic [15:0] AGE_MAX       = 16'hFFFF;
    localparam logic [15:0] POLL_RESET    = 16'd5;
    localparam logic [3:0]  REPEATS_RESET = 4'd3;

    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 16;

    localparam logic [CfgIdxW-1:0] REG_POLL_INTERVAL = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_QUERY_REPEATS = 2'd1;

    typedef enum logic [2:0] {
        REJ_NONE     = 3'd0,
        REJ_GARBAGE  = 3'd1,
        REJ_LENGTH   = 3'd2,
        REJ_END      = 3'd3,
        REJ_CHECKSUM = 3'd4
    } reject_t;

    typedef struct packed {
        logic       send;
        logic [3:0] count;
    } poll_result_t;

endpackage

`default_nettype wire

// File: src/co_sensor_frame_receiver_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// co_sensor_frame_receiver_unit: CO sensor frame receiver
// Assembles 19-byte sensor frames from a shifting byte window, checks them,
// latches sensor values, ages the last frame and runs the poll timer.
//
//   channel | signals                           | role
//   --------+-----------------------------------+-----------------------------
//   in      | in_valid, in_stall, mode, rx_byte | byte or one-second tick
//   out     | out_valid, out_stall, results     | one result per request
//   cfg     | cfg_we, cfg_index, cfg_data       | poll_interval, query_repeats
//
// One request per cycle while in_stall is low; each is finished in the cycle
// it is taken, and its result sits in the output register the next cycle.
// Every byte shifts the cell chain by one, so a full window is checked against
// fixed cells. in_stall is high only while a result waits and out_stall is
// high. Reset clears control state; window cells hold no reset value.
// ----------------------------------------------------------------------------
module co_sensor_frame_receiver_unit
    import co_sfr_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic                mode,
    input  wire logic [7:0]          rx_byte,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic                     frame_valid,
    output logic [2:0]               reject_kind,
    output logic [15:0]              co_ppm,
    output logic                     alarm,
    output logic                     fault,
    output logic                     changed,
    output logic [7:0]               status_byte,
    output logic [7:0]               event_byte,
    output logic                     send_query,
    output logic [3:0]               query_count,
    output logic signed [16:0]       frame_age,
    input  wire logic                cfg_we,
    input  wire logic [CfgIdxW-1:0]  cfg_index,
    input  wire logic [CfgDataW-1:0] cfg_data
);

    logic accept;
    logic byte_in;
    logic tick_in;

    logic [7:0] cell_q [FrameLen];

    logic [4:0] fill_reg;
    logic [4:0] fill_next;
    logic [7:0] sum_reg;
    logic [7:0] sum_next;

    logic [15:0]        ppm_reg;
    logic               alarm_reg;
    logic               fault_reg;
    logic [7:0]         status_reg;
    logic [7:0]         event_reg;
    logic signed [16:0] age_reg;

    logic       out_valid_reg;
    logic       frame_valid_reg;
    reject_t    reject_reg;
    logic       changed_reg;
    logic       send_reg;
    logic [3:0] count_reg;

    logic       full_check;
    reject_t    reject_next;
    logic       good_frame;
    logic [15:0] frame_ppm;
    logic       frame_alarm;
    logic       frame_fault;
    logic       changed_next;

    poll_result_t poll_res;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign byte_in  = accept && !mode;
    assign tick_in  = accept && mode;

    // newest byte enters the last cell, older bytes move toward cell 0
    genvar gi;
    generate
        for (gi = 0; gi < FrameLen; gi++)
        begin : g_cell
            logic [7:0] cell_d;
            if (gi == FrameLen - 1)
            begin : g_last
                assign cell_d = rx_byte;
            end
            else
            begin : g_mid
                assign cell_d = cell_q[gi+1];
            end
            co_sfr_cell u_cell (
                .clk   (clk),
                .shift (byte_in),
                .din   (cell_d),
                .dout  (cell_q[gi])
            );
        end
    endgenerate

    // with 18 bytes held they sit in cells 1..18; the new byte completes it
    assign full_check  = (fill_reg == 5'(FrameLen - 1));
    assign frame_ppm   = {cell_q[9], cell_q[10]};
    assign frame_alarm = |(cell_q[4] & ALARM_MASK);
    assign frame_fault = |(cell_q[4] & FAULT_MASK);

    always_comb
    begin
        if (cell_q[1] != HDR_BYTE)
        begin
            reject_next = REJ_GARBAGE;
        end
        else if (cell_q[2] != LEN_BYTE)
        begin
            reject_next = REJ_LENGTH;
        end
        else if (cell_q[18] != END_BYTE)
        begin
            reject_next = REJ_END;
        end
        else if (sum_reg != rx_byte)
        begin
            reject_next = REJ_CHECKSUM;
        end
        else
        begin
            reject_next = REJ_NONE;
        end
    end

    assign good_frame   = full_check && (reject_next == REJ_NONE);
    assign changed_next = (frame_ppm != ppm_reg) || (frame_alarm != alarm_reg)
                          || (frame_fault != fault_reg);

    always_comb
    begin
        fill_next = fill_reg + 5'd1;
        sum_next  = sum_reg + rx_byte;
        if (full_check)
        begin
            if (good_frame)
            begin
                fill_next = 5'd0;
                sum_next  = 8'd0;
            end
            else
            begin
                fill_next = 5'(FrameLen - 1);
                sum_next  = sum_reg + rx_byte - cell_q[1];
            end
        end
    end

    co_sfr_poll u_poll (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tick      (tick_in),
        .result    (poll_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg        <= 5'd0;
            sum_reg         <= 8'd0;
            ppm_reg         <= 16'd0;
            alarm_reg       <= 1'b0;
            fault_reg       <= 1'b0;
            status_reg      <= 8'd0;
            event_reg       <= 8'd0;
            age_reg         <= -17'sd1;
            out_valid_reg   <= 1'b0;
            frame_valid_reg <= 1'b0;
            reject_reg      <= REJ_NONE;
            changed_reg     <= 1'b0;
            send_reg        <= 1'b0;
            count_reg       <= 4'd0;
        end
        else
        begin
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (byte_in)
            begin
                fill_reg        <= fill_next;
                sum_reg         <= sum_next;
                frame_valid_reg <= good_frame;
                reject_reg      <= full_check ? reject_next : REJ_NONE;
                changed_reg     <= good_frame && changed_next;
                send_reg        <= 1'b0;
                count_reg       <= 4'd0;
                if (good_frame)
                begin
                    ppm_reg    <= frame_ppm;
                    alarm_reg  <= frame_alarm;
                    fault_reg  <= frame_fault;
                    status_reg <= cell_q[4];
                    event_reg  <= cell_q[11];
                    age_reg    <= 17'sd0;
                end
            end

            if (tick_in)
            begin
                frame_valid_reg <= 1'b0;
                reject_reg      <= REJ_NONE;
                changed_reg     <= 1'b0;
                send_reg        <= poll_res.send;
                count_reg       <= poll_res.count;
                if (!age_reg[16] && age_reg[15:0] != AGE_MAX)
                begin
                    age_reg <= age_reg + 17'sd1;
                end
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign frame_valid = frame_valid_reg;
    assign reject_kind = reject_reg;
    assign co_ppm      = ppm_reg;
    assign alarm       = alarm_reg;
    assign fault       = fault_reg;
    assign changed     = changed_reg;
    assign status_byte = status_reg;
    assign event_byte  = event_reg;
    assign send_query  = send_reg;
    assign query_count = count_reg;
    assign frame_age   = age_reg;

endmodule

`default_nettype wire

// File: src/co_sfr_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// co_sfr_cell: one byte cell of the receive window
// Holds one byte; on a shift it loads its din (next cell's or new byte).
// ----------------------------------------------------------------------------
module co_sfr_cell
    import co_sfr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       shift,
    input  wire logic [7:0] din,
    output logic [7:0]      dout
);

    logic [7:0] byte_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            byte_reg <= din;
        end
    end

    assign dout = byte_reg;

endmodule

`default_nettype wire

// File: src/co_sfr_poll.sv
`default_nettype none
// ----------------------------------------------------------------------------
// co_sfr_poll: poll timer
// Holds the poll registers and countdown; requests query bursts on ticks.
// ----------------------------------------------------------------------------
module co_sfr_poll
    import co_sfr_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [CfgIdxW-1:0]  cfg_index,
    input  wire logic [CfgDataW-1:0] cfg_data,
    input  wire logic                tick,
    output poll_result_t             result
);

    logic [15:0] interval_reg;
    logic [3:0]  repeats_reg;
    logic [15:0] countdown_reg;
    logic [15:0] countdown_next;
    logic [3:0]  count_clamped;

    always_comb
    begin
        if (repeats_reg == 4'd0)
        begin
            count_clamped = 4'd1;
        end
        else if (repeats_reg > MAX_REPEATS)
        begin
            count_clamped = MAX_REPEATS;
        end
        else
        begin
            count_clamped = repeats_reg;
        end
    end

    always_comb
    begin
        result         = '0;
        countdown_next = countdown_reg;
        if (tick && interval_reg != 16'd0)
        begin
            if (countdown_reg == 16'd0)
            begin
                result.send    = 1'b1;
                result.count   = count_clamped;
                countdown_next = interval_reg;
            end
            else
            begin
                countdown_next = countdown_reg - 16'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg  <= POLL_RESET;
            repeats_reg   <= REPEATS_RESET;
            countdown_reg <= 16'd0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_POLL_INTERVAL)
            begin
                interval_reg  <= cfg_data[15:0];
                countdown_reg <= 16'd0;
            end
            else if (cfg_index == REG_QUERY_REPEATS)
            begin
                repeats_reg <= cfg_data[3:0];
            end
        end
        else
        begin
            countdown_reg <= countdown_next;
        end
    end

endmodule

`default_nettype wire

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: CO sensor frame receiver testbench
// Feeds serial bytes and one-second ticks through the request channel and
// checks every result against a cycle-free predictor of the frame window,
// the latched sensor values, the frame age and the poll timer. Covers the
// reject kinds, poll register settings, frame aging and random traffic
// under sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb;
    import co_sfr_pkg::*;

    localparam int unsigned CYCLE_LIMIT    = 1_000_000;
    localparam int unsigned PHASE_REQUESTS = 195;

    localparam int DAMAGE_HEADER = 1;
    localparam int DAMAGE_LENGTH = 2;
    localparam int DAMAGE_END    = 4;
    localparam int DAMAGE_SUM    = 8;

    localparam logic [CfgIdxW-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_SPARE_3 = 2'd3;

    typedef struct {
        logic               frame_valid;
        reject_t            reject_kind;
        logic [15:0]        co_ppm;
        logic               alarm;
        logic               fault;
        logic               changed;
        logic [7:0]         status_byte;
        logic [7:0]         event_byte;
        logic               send_query;
        logic [3:0]         query_count;
        logic signed [16:0] frame_age;
    } sensor_report_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic                mode = 1'b0;
    logic [7:0]          rx_byte = 8'h00;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic                frame_valid;
    logic [2:0]          reject_kind;
    logic [15:0]         co_ppm;
    logic                alarm;
    logic                fault;
    logic                changed;
    logic [7:0]          status_byte;
    logic [7:0]          event_byte;
    logic                send_query;
    logic [3:0]          query_count;
    logic signed [16:0]  frame_age;
    logic                cfg_we = 1'b0;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [CfgDataW-1:0] cfg_data = '0;

    // predictor state
    logic [7:0]  rx_window [FrameLen];
    int          window_count = 0;
    logic [7:0]  window_total = 8'h00;
    logic [15:0] held_ppm = 16'h0000;
    logic        held_alarm = 1'b0;
    logic        held_fault = 1'b0;
    logic [7:0]  held_status = 8'h00;
    logic [7:0]  held_event = 8'h00;
    int          seconds_since_frame = -1;
    logic [15:0] poll_remaining = 16'h0000;
    logic [15:0] poll_period = POLL_RESET;
    logic [3:0]  burst_setting = REPEATS_RESET;

    sensor_report_t expected_reports [$];
    int unsigned    mismatch_count = 0;
    int unsigned    requests_sent = 0;
    int unsigned    cycle_count = 0;
    int unsigned    sender_idle_pct = 0;
    int unsigned    receiver_stall_pct = 0;

    co_sensor_frame_receiver_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .frame_valid (frame_valid),
        .reject_kind (reject_kind),
        .co_ppm      (co_ppm),
        .alarm       (alarm),
        .fault       (fault),
        .changed     (changed),
        .status_byte (status_byte),
        .event_byte  (event_byte),
        .send_query  (send_query),
        .query_count (query_count),
        .frame_age   (frame_age),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        out_stall   <= ($urandom_range(99) < receiver_stall_pct);
    end

    function automatic sensor_report_t predict_report(logic tick, logic [7:0] b);
        sensor_report_t r;
        logic [7:0]     body;
        logic [15:0]    ppm;
        logic           al;
        logic           fa;
        r.frame_valid = 1'b0;
        r.reject_kind = REJ_NONE;
        r.changed     = 1'b0;
        r.send_query  = 1'b0;
        r.query_count = 4'd0;
        if (!tick)
        begin
            rx_window[window_count] = b;
            window_count++;
            window_total += b;
            if (window_count == FrameLen)
            begin
                body = window_total - rx_window[FrameLen-1];
                if (rx_window[0] != HDR_BYTE)
                    r.reject_kind = REJ_GARBAGE;
                else if (rx_window[1] != LEN_BYTE)
                    r.reject_kind = REJ_LENGTH;
                else if (rx_window[17] != END_BYTE)
                    r.reject_kind = REJ_END;
                else if (body != rx_window[FrameLen-1])
                    r.reject_kind = REJ_CHECKSUM;
                if (r.reject_kind != REJ_NONE)
                begin
                    window_total -= rx_window[0];
                    for (int i = 0; i < FrameLen - 1; i++)
                        rx_window[i] = rx_window[i+1];
                    window_count = FrameLen - 1;
                end
                else
                begin
                    ppm = {rx_window[8], rx_window[9]};
                    al  = (rx_window[3] & ALARM_MASK) != 0;
                    fa  = (rx_window[3] & FAULT_MASK) != 0;
                    r.changed = (ppm != held_ppm) || (al != held_alarm) || (fa != held_fault);
                    held_ppm    = ppm;
                    held_alarm  = al;
                    held_fault  = fa;
                    held_status = rx_window[3];
                    held_event  = rx_window[10];
                    seconds_since_frame = 0;
                    r.frame_valid = 1'b1;
                    window_count  = 0;
                    window_total  = 8'h00;
                end
            end
        end
        else
        begin
            if (seconds_since_frame >= 0 && seconds_since_frame < int'(AGE_MAX))
                seconds_since_frame++;
            if (poll_period != 16'h0000)
            begin
                if (poll_remaining == 16'h0000)
                begin
                    r.send_query = 1'b1;
                    if (burst_setting == 4'd0)
                        r.query_count = 4'd1;
                    else if (burst_setting > MAX_REPEATS)
                        r.query_count = MAX_REPEATS;
                    else
                        r.query_count = burst_setting;
                    poll_remaining = poll_period;
                end
                else
                begin
                    poll_remaining--;
                end
            end
        end
        r.co_ppm      = held_ppm;
        r.alarm       = held_alarm;
        r.fault       = held_fault;
        r.status_byte = held_status;
        r.event_byte  = held_event;
        r.frame_age   = 17'(seconds_since_frame);
        return r;
    endfunction

    task automatic compare_field(string name, logic signed [31:0] want,
                                 logic signed [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        sensor_report_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_reports.size() == 0)
                begin
                    $error("result with no request outstanding");
                    mismatch_count++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    compare_field("frame_valid", want.frame_valid, frame_valid);
                    compare_field("reject_kind", want.reject_kind, reject_kind);
                    compare_field("co_ppm", want.co_ppm, co_ppm);
                    compare_field("alarm", want.alarm, alarm);
                    compare_field("fault", want.fault, fault);
                    compare_field("changed", want.changed, changed);
                    compare_field("status_byte", want.status_byte, status_byte);
                    compare_field("event_byte", want.event_byte, event_byte);
                    compare_field("send_query", want.send_query, send_query);
                    compare_field("query_count", want.query_count, query_count);
                    compare_field("frame_age", want.frame_age, frame_age);
                end
            end
            if (in_valid && !in_stall)
                expected_reports.push_back(predict_report(mode, rx_byte));
        end
    end

    task automatic send_request(logic tick, logic [7:0] b);
        if ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
        end
        in_valid <= 1'b1;
        mode     <= tick;
        rx_byte  <= b;
        do @(posedge clk); while (in_stall);
        requests_sent++;
    endtask

    task automatic send_ticks(int unsigned n);
        repeat (n) send_request(1'b1, 8'($urandom));
    endtask

    task automatic send_frame(logic [15:0] ppm, logic [7:0] status, logic [7:0] evt,
                              int damage, int unsigned tick_pct);
        logic [7:0] f [FrameLen];
        logic [7:0] total;
        total = 8'h00;
        foreach (f[i])
            f[i] = 8'($urandom);
        f[0]  = HDR_BYTE;
        f[1]  = LEN_BYTE;
        f[3]  = status;
        f[8]  = ppm[15:8];
        f[9]  = ppm[7:0];
        f[10] = evt;
        f[17] = END_BYTE;
        if ((damage & DAMAGE_HEADER) != 0)
            f[0] ^= 8'($urandom_range(1, 255));
        if ((damage & DAMAGE_LENGTH) != 0)
            f[1] ^= 8'($urandom_range(1, 255));
        if ((damage & DAMAGE_END) != 0)
            f[17] ^= 8'($urandom_range(1, 255));
        for (int i = 0; i < FrameLen - 1; i++)
            total += f[i];
        f[FrameLen-1] = total;
        if ((damage & DAMAGE_SUM) != 0)
            f[FrameLen-1] ^= 8'($urandom_range(1, 255));
        for (int i = 0; i < FrameLen; i++)
        begin
            if ($urandom_range(99) < tick_pct)
                send_request(1'b1, 8'($urandom));
            send_request(1'b0, f[i]);
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_POLL_INTERVAL)
        begin
            poll_period    = data;
            poll_remaining = 16'h0000;
        end
        else if (idx == REG_QUERY_REPEATS)
        begin
            burst_setting = data[3:0];
        end
        @(posedge clk);
    endtask

    // tick before any frame, a garbage byte ahead of a frame at the field extremes
    task automatic test_directed_edges();
        send_request(1'b1, 8'hFF);
        send_request(1'b0, 8'h00);
        send_frame(16'hFFFF, 8'h60, 8'hFF, 0, 0);
        send_request(1'b1, 8'h00);
        wait_idle();
    endtask

    task automatic test_frame_checks();
        send_frame(16'hFFFF, 8'h60, 8'h00, 0, 0);
        send_frame(16'h0101, 8'h00, 8'h11, DAMAGE_LENGTH, 0);
        send_frame(16'h0202, 8'h00, 8'h22, DAMAGE_END, 0);
        send_frame(16'h0303, 8'h00, 8'h33, DAMAGE_SUM, 0);
        send_frame(16'h0404, 8'h00, 8'h44, DAMAGE_HEADER | DAMAGE_LENGTH, 0);
        send_frame(16'h0505, 8'h00, 8'h55, DAMAGE_LENGTH | DAMAGE_END | DAMAGE_SUM, 0);
        send_frame(16'h0606, 8'h00, 8'h66, DAMAGE_END | DAMAGE_SUM, 0);
        send_frame(16'h0000, 8'h20, 8'h00, 0, 0);
        send_frame(16'h0000, 8'h00, 8'h77, 0, 0);
        wait_idle();
    endtask

    task automatic test_poll_settings();
        write_register(REG_POLL_INTERVAL, 16'h0000);
        send_ticks(3);
        wait_idle();
        write_register(REG_POLL_INTERVAL, 16'h0001);
        write_register(REG_QUERY_REPEATS, 16'h0000);
        send_ticks(4);
        wait_idle();
        write_register(REG_QUERY_REPEATS, 16'hFFFF);
        send_ticks(2);
        wait_idle();
        write_register(REG_QUERY_REPEATS, 16'h000A);
        write_register(REG_SPARE_2, 16'hFFFF);
        write_register(REG_SPARE_3, 16'h0000);
        send_ticks(3);
        wait_idle();
        write_register(REG_POLL_INTERVAL, 16'hFFFF);
        write_register(REG_QUERY_REPEATS, 16'h0001);
        send_ticks(3);
        wait_idle();
    endtask

    // age restarts at zero on a good frame and counts up on ticks
    task automatic test_frame_aging();
        send_frame(16'h1234, 8'h40, 8'h01, 0, 0);
        send_ticks(5);
        wait_idle();
    endtask

    task automatic test_random_traffic();
        int unsigned idle_by_phase [4]  = '{0, 85, 0, 6};
        int unsigned stall_by_phase [4] = '{0, 0, 85, 6};
        int unsigned phase_start;
        int unsigned pick;
        logic [15:0] ppm;
        logic [7:0]  status;
        ppm    = 16'h0000;
        status = 8'h00;
        for (int p = 0; p < 4; p++)
        begin
            sender_idle_pct    = idle_by_phase[p];
            receiver_stall_pct = stall_by_phase[p];
            case ($urandom_range(3))
                0:       write_register(REG_POLL_INTERVAL, 16'h0000);
                1:       write_register(REG_POLL_INTERVAL, 16'($urandom));
                default: write_register(REG_POLL_INTERVAL, 16'($urandom_range(1, 6)));
            endcase
            write_register(REG_QUERY_REPEATS, 16'($urandom));
            phase_start = requests_sent;
            while (requests_sent - phase_start < PHASE_REQUESTS)
            begin
                pick = $urandom_range(99);
                if (pick < 70)
                begin
                    if ($urandom_range(99) >= 30)
                    begin
                        ppm    = 16'($urandom);
                        status = 8'($urandom);
                    end
                    send_frame(ppm, status, 8'($urandom),
                               ($urandom_range(99) < 60) ? 0 : int'($urandom_range(1, 15)), 5);
                end
                else if (pick < 85)
                begin
                    repeat ($urandom_range(1, 20)) send_request(1'b0, 8'($urandom));
                end
                else
                begin
                    send_ticks($urandom_range(1, 6));
                end
            end
            wait_idle();
        end
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
    endtask

    initial
    begin
        wait (cycle_count == CYCLE_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_edges();
        test_frame_checks();
        test_poll_settings();
        test_frame_aging();
        test_random_traffic();
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
